[rtl/rdc_pkg.sv]
package rdc_pkg;

    // default sizes
    localparam int VALUE_BITS_DEF     = 32;
    localparam int MAX_OUT_DIGITS_DEF = 32;

    // field widths
    localparam int CHAR_W     = 8;
    localparam int BASE_W     = 5;
    localparam int DIGIT_W    = 4;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // radix limits and register reset values
    localparam logic [BASE_W-1:0] BASE_MIN        = 5'd2;
    localparam logic [BASE_W-1:0] BASE_MAX        = 5'd16;
    localparam logic [BASE_W-1:0] SOURCE_BASE_RST = 5'd10;
    localparam logic [BASE_W-1:0] TARGET_BASE_RST = 5'd16;

    // character codes
    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_A    = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_F    = 8'h46;
    localparam logic [CHAR_W-1:0] CHAR_TEN  = 8'd10;

    // digit value of a character that is no hex digit at all
    localparam logic [BASE_W-1:0]  DIGIT_NONE = 5'd16;
    localparam logic [DIGIT_W-1:0] DIGIT_TEN  = 4'd10;

    // register index, taken from paddr bit 2
    typedef enum logic [0:0] {
        REG_SOURCE_BASE = 1'b0,
        REG_TARGET_BASE = 1'b1
    } reg_idx_t;

    // controller to datapath commands
    typedef struct packed {
        logic acc_en;
        logic div_load;
        logic div_step;
        logic push;
        logic set_wrap;
        logic rd_en;
        logic load_out;
        logic clear_num;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic div_done;
        logic quo_zero;
        logic stack_top;
        logic stack_empty;
        logic out_free;
    } dp_sts_t;

    // radix below two acts as two, above sixteen as sixteen
    function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
        logic [BASE_W-1:0] r;
        if (b < BASE_MIN)
            r = BASE_MIN;
        else if (b > BASE_MAX)
            r = BASE_MAX;
        else
            r = b;
        return r;
    endfunction

    // hex character to digit value, DIGIT_NONE when not a hex digit
    function automatic logic [BASE_W-1:0] char_value(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] diff;
        logic [BASE_W-1:0] r;
        diff = '0;
        r    = DIGIT_NONE;
        if (c >= CHAR_ZERO && c <= CHAR_NINE)
        begin
            diff = c - CHAR_ZERO;
            r    = diff[BASE_W-1:0];
        end
        else if (c >= CHAR_A && c <= CHAR_F)
        begin
            diff = c - CHAR_A + CHAR_TEN;
            r    = diff[BASE_W-1:0];
        end
        return r;
    endfunction

    // digit value to uppercase character
    function automatic logic [CHAR_W-1:0] digit_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] r;
        if (d < DIGIT_TEN)
            r = CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, d};
        else
            r = CHAR_A + {{(CHAR_W-DIGIT_W){1'b0}}, d} - CHAR_TEN;
        return r;
    endfunction

endpackage

[rtl/rdc_in_if.sv]
interface rdc_in_if;
    logic                        valid;
    logic                        ready;
    logic [rdc_pkg::CHAR_W-1:0]  digit_char;
    logic                        last_digit;

    modport source (output valid, digit_char, last_digit, input ready);
    modport sink   (input valid, digit_char, last_digit, output ready);
endinterface

[rtl/rdc_out_if.sv]
interface rdc_out_if;
    logic                        valid;
    logic                        ready;
    logic [rdc_pkg::CHAR_W-1:0]  out_char;
    logic                        out_last;
    logic                        bad_digit;
    logic                        overflowed;

    modport source (output valid, out_char, out_last, bad_digit, overflowed, input ready);
    modport sink   (input valid, out_char, out_last, bad_digit, overflowed, output ready);
endinterface

[rtl/rdc_regs.sv]
module rdc_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rdc_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [rdc_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [rdc_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    output logic [rdc_pkg::BASE_W-1:0]       source_base,
    output logic [rdc_pkg::BASE_W-1:0]       target_base
);

    logic [rdc_pkg::BASE_W-1:0] source_base_reg;
    logic [rdc_pkg::BASE_W-1:0] source_base_next;
    logic [rdc_pkg::BASE_W-1:0] target_base_reg;
    logic [rdc_pkg::BASE_W-1:0] target_base_next;
    rdc_pkg::reg_idx_t          reg_idx;
    logic                       wr_en;

    assign reg_idx = rdc_pkg::reg_idx_t'(paddr[2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // register write decode
    always_comb
    begin
        source_base_next = source_base_reg;
        target_base_next = target_base_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                rdc_pkg::REG_SOURCE_BASE: source_base_next = pwdata[rdc_pkg::BASE_W-1:0];
                rdc_pkg::REG_TARGET_BASE: target_base_next = pwdata[rdc_pkg::BASE_W-1:0];
                default:                  source_base_next = source_base_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_base_reg <= rdc_pkg::SOURCE_BASE_RST;
            target_base_reg <= rdc_pkg::TARGET_BASE_RST;
        end
        else
        begin
            source_base_reg <= source_base_next;
            target_base_reg <= target_base_next;
        end
    end

    // read mux
    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            rdc_pkg::REG_SOURCE_BASE: prdata[rdc_pkg::BASE_W-1:0] = source_base_reg;
            rdc_pkg::REG_TARGET_BASE: prdata[rdc_pkg::BASE_W-1:0] = target_base_reg;
            default:                  prdata = '0;
        endcase
    end

    assign source_base = source_base_reg;
    assign target_base = target_base_reg;

endmodule

[rtl/rdc_dp.sv]
module rdc_dp #(
    parameter int VALUE_BITS     = rdc_pkg::VALUE_BITS_DEF,
    parameter int MAX_OUT_DIGITS = rdc_pkg::MAX_OUT_DIGITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rdc_pkg::dp_cmd_t              cmd,
    input  logic [rdc_pkg::BASE_W-1:0]    source_base,
    input  logic [rdc_pkg::BASE_W-1:0]    target_base,
    input  logic [rdc_pkg::CHAR_W-1:0]    digit_char,
    input  logic                          out_ready,
    output rdc_pkg::dp_sts_t              sts,
    output logic                          out_valid,
    output logic [rdc_pkg::CHAR_W-1:0]    out_char,
    output logic                          out_last,
    output logic                          bad_digit,
    output logic                          overflowed
);

    localparam int PROD_W = VALUE_BITS + rdc_pkg::BASE_W;
    localparam int IDX_W  = $clog2(MAX_OUT_DIGITS);
    localparam int CNT_W  = $clog2(MAX_OUT_DIGITS + 1);
    localparam int BIT_W  = $clog2(VALUE_BITS + 1);
    localparam int DW     = rdc_pkg::DIGIT_W;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_OUT_DIGITS);
    localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(MAX_OUT_DIGITS - 1);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
    localparam logic [BIT_W-1:0] BIT_END = BIT_W'(VALUE_BITS);
    localparam logic [BIT_W-1:0] BIT_ONE = BIT_W'(1);

    // number accumulation
    logic [VALUE_BITS-1:0]        acc_reg;
    logic [VALUE_BITS-1:0]        acc_next;
    logic                         bad_reg;
    logic                         bad_next;
    logic                         wrap_reg;
    logic                         wrap_next;
    logic [rdc_pkg::BASE_W-1:0]   sb;
    logic [rdc_pkg::BASE_W-1:0]   tb;
    logic [rdc_pkg::BASE_W-1:0]   dval;
    logic                         dig_ok;
    logic [PROD_W-1:0]            prod;
    logic [PROD_W-1:0]            sum;

    // bit-serial divider
    logic [VALUE_BITS-1:0]        quo_reg;
    logic [VALUE_BITS-1:0]        quo_next;
    logic [DW-1:0]                rem_reg;
    logic [DW-1:0]                rem_next;
    logic [BIT_W-1:0]             bit_cnt_reg;
    logic [BIT_W-1:0]             bit_cnt_next;
    logic [rdc_pkg::BASE_W-1:0]   rem_shift;
    logic [rdc_pkg::BASE_W-1:0]   rem_sub;
    logic                         q_bit;
    logic [DW-1:0]                rem_step;

    // digit stack
    logic [DW-1:0]                stack_mem [MAX_OUT_DIGITS];
    logic [CNT_W-1:0]             cnt_reg;
    logic [CNT_W-1:0]             cnt_next;
    logic [CNT_W-1:0]             cnt_dec;
    logic [DW-1:0]                rd_data_reg;

    // output register
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [rdc_pkg::CHAR_W-1:0]   out_char_reg;
    logic                         out_last_reg;
    logic                         out_bad_reg;
    logic                         out_wrap_reg;

    // horner step: acc * base + digit, upper bits flag a wrap
    assign sb     = rdc_pkg::clamp_base(source_base);
    assign tb     = rdc_pkg::clamp_base(target_base);
    assign dval   = rdc_pkg::char_value(digit_char);
    assign dig_ok = dval < sb;
    assign prod   = PROD_W'(acc_reg) * PROD_W'(sb);
    assign sum    = prod + PROD_W'(dval);

    always_comb
    begin
        acc_next  = acc_reg;
        bad_next  = bad_reg;
        wrap_next = wrap_reg;
        if (cmd.clear_num)
        begin
            acc_next  = '0;
            bad_next  = 1'b0;
            wrap_next = 1'b0;
        end
        else
        begin
            if (cmd.acc_en)
            begin
                if (dig_ok)
                begin
                    acc_next = sum[VALUE_BITS-1:0];
                    if (sum[PROD_W-1:VALUE_BITS] != '0)
                        wrap_next = 1'b1;
                end
                else
                begin
                    bad_next = 1'b1;
                end
            end
            if (cmd.set_wrap)
                wrap_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            bad_reg  <= 1'b0;
            wrap_reg <= 1'b0;
        end
        else
        begin
            acc_reg  <= acc_next;
            bad_reg  <= bad_next;
            wrap_reg <= wrap_next;
        end
    end

    // restoring division, one quotient bit per cycle
    assign rem_shift = {rem_reg, quo_reg[VALUE_BITS-1]};
    assign q_bit     = rem_shift >= tb;
    assign rem_sub   = rem_shift - tb;
    assign rem_step  = q_bit ? rem_sub[DW-1:0] : rem_shift[DW-1:0];

    always_comb
    begin
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        bit_cnt_next = bit_cnt_reg;
        if (cmd.div_load)
        begin
            quo_next     = acc_reg;
            rem_next     = '0;
            bit_cnt_next = '0;
        end
        else if (cmd.div_step)
        begin
            quo_next     = {quo_reg[VALUE_BITS-2:0], q_bit};
            rem_next     = rem_step;
            bit_cnt_next = bit_cnt_reg + BIT_ONE;
        end
        else if (cmd.push)
        begin
            // quotient stays as the next dividend
            rem_next     = '0;
            bit_cnt_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bit_cnt_reg <= '0;
        else
            bit_cnt_reg <= bit_cnt_next;
    end

    // stack fill count
    assign cnt_dec = cnt_reg - CNT_ONE;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.div_load)
            cnt_next = '0;
        else if (cmd.push)
            cnt_next = cnt_reg + CNT_ONE;
        else if (cmd.rd_en)
            cnt_next = cnt_dec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    // remainder memory, least significant digit at the bottom
    always_ff @(posedge clk)
    begin
        if (cmd.push)
            stack_mem[cnt_reg[IDX_W-1:0]] <= rem_reg;
        if (cmd.rd_en)
            rd_data_reg <= stack_mem[cnt_dec[IDX_W-1:0]];
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_char_reg <= rdc_pkg::digit_ascii(rd_data_reg);
            out_last_reg <= cnt_reg == '0;
            out_bad_reg  <= bad_reg;
            out_wrap_reg <= wrap_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_char   = out_char_reg;
    assign out_last   = out_last_reg;
    assign bad_digit  = out_bad_reg;
    assign overflowed = out_wrap_reg;

    // status to controller
    assign sts.div_done    = bit_cnt_reg == BIT_END;
    assign sts.quo_zero    = quo_reg == '0;
    assign sts.stack_top   = cnt_reg == CNT_TOP;
    assign sts.stack_empty = cnt_reg == '0;
    assign sts.out_free    = !out_valid_reg || out_ready;

`ifndef SYNTH
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_MAX)
        else $error("digit stack count beyond depth");

    a_push_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> bit_cnt_reg == BIT_END)
        else $error("remainder pushed before division finished");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> bit_cnt_reg < BIT_END)
        else $error("division stepped past the dividend width");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("output register overwritten while held");

    a_read_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_en |-> cnt_reg != '0)
        else $error("read from empty digit stack");
`endif

endmodule

[rtl/rdc_ctrl.sv]
module rdc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              last_digit,
    input  rdc_pkg::dp_sts_t  sts,
    output logic              in_ready,
    output rdc_pkg::dp_cmd_t  cmd
);

    typedef enum logic [4:0] {
        ST_ACC  = 5'b00001,
        ST_LOAD = 5'b00010,
        ST_DIV  = 5'b00100,
        ST_READ = 5'b01000,
        ST_EMIT = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_fire;

    assign in_ready = state_reg == ST_ACC;
    assign in_fire  = in_valid && in_ready;

    // sequencing: accumulate, divide per digit, pop and emit
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_ACC:
            begin
                cmd.acc_en = in_fire;
                if (in_fire && last_digit)
                    state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                cmd.div_load = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                if (!sts.div_done)
                begin
                    cmd.div_step = 1'b1;
                end
                else
                begin
                    cmd.push = 1'b1;
                    if (sts.quo_zero)
                    begin
                        state_next = ST_READ;
                    end
                    else if (sts.stack_top)
                    begin
                        // stack full with value left: drop the high digits
                        cmd.set_wrap = 1'b1;
                        state_next   = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    if (sts.stack_empty)
                    begin
                        cmd.clear_num = 1'b1;
                        state_next    = ST_ACC;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_ACC;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_ACC;
        else
            state_reg <= state_next;
    end

`ifndef SYNTH
    a_accept_only_acc: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |-> state_reg == ST_ACC)
        else $error("digit taken outside accumulation");

    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && last_digit) |=> (state_reg == ST_LOAD && !in_ready))
        else $error("final digit did not start conversion");

    a_final_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_out && sts.stack_empty) |=> state_reg == ST_ACC)
        else $error("controller did not return after final digit");
`endif

endmodule

[rtl/radix_digit_converter_top.sv]
// channel   dir   payload                                     transaction
// in_ch     in    digit_char[7:0], last_digit                 valid & ready
// out_ch    out   out_char[7:0], out_last, bad_digit,          valid & ready
//                 overflowed
// apb       in    source_base @ 0x0, target_base @ 0x4        psel & penable & pwrite
//
// an input digit is accumulated when taken; the final digit starts a conversion
// each result digit is a remainder of the bit-serial divider, and each emitted
// character takes a stack memory read and then an output register load
// input ready stays low from the final digit until the last result is loaded
// a stalled output holds emission; the digit stack needs no clearing after reset
module radix_digit_converter_top #(
    parameter int VALUE_BITS     = rdc_pkg::VALUE_BITS_DEF,
    parameter int MAX_OUT_DIGITS = rdc_pkg::MAX_OUT_DIGITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    rdc_in_if.sink                          in_ch,
    rdc_out_if.source                       out_ch,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rdc_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [rdc_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [rdc_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    logic [rdc_pkg::BASE_W-1:0] source_base;
    logic [rdc_pkg::BASE_W-1:0] target_base;
    rdc_pkg::dp_cmd_t           cmd;
    rdc_pkg::dp_sts_t           sts;

    // configuration registers
    rdc_regs u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .source_base (source_base),
        .target_base (target_base)
    );

    // sequencer
    rdc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_ch.valid),
        .last_digit (in_ch.last_digit),
        .sts        (sts),
        .in_ready   (in_ch.ready),
        .cmd        (cmd)
    );

    // accumulator, divider, digit stack and output register
    rdc_dp #(
        .VALUE_BITS     (VALUE_BITS),
        .MAX_OUT_DIGITS (MAX_OUT_DIGITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .source_base (source_base),
        .target_base (target_base),
        .digit_char  (in_ch.digit_char),
        .out_ready   (out_ch.ready),
        .sts         (sts),
        .out_valid   (out_ch.valid),
        .out_char    (out_ch.out_char),
        .out_last    (out_ch.out_last),
        .bad_digit   (out_ch.bad_digit),
        .overflowed  (out_ch.overflowed)
    );

endmodule
